@@ rtl/i2c_master_transaction_sequencer_defines.svh @@
// assertion helpers used by the sequencer core rtl
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CMTS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMTS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cmts_pkg.sv @@
`default_nettype none

package i2cmts_pkg;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  localparam logic [3:0] EV_START_SENT  = 4'd0;
  localparam logic [3:0] EV_WR_ADDR_ACK  = 4'd1;
  localparam logic [3:0] EV_WR_DATA_ACK  = 4'd2;
  localparam logic [3:0] EV_WR_ADDR_NACK = 4'd3;
  localparam logic [3:0] EV_WR_DATA_NACK = 4'd4;
  localparam logic [3:0] EV_RD_ADDR_ACK  = 4'd5;
  localparam logic [3:0] EV_RD_ADDR_NACK = 4'd6;
  localparam logic [3:0] EV_RD_DATA_ACK  = 4'd7;
  localparam logic [3:0] EV_RD_DATA_NACK = 4'd8;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_NACK    = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_BUSY       = 3'd1;
  localparam logic [2:0] ERR_PARAM      = 3'd2;
  localparam logic [2:0] ERR_WRITE_NACK = 3'd3;
  localparam logic [2:0] ERR_READ       = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd5;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd6;

  localparam logic [7:0]  ADDR_LIMIT    = 8'h7F;
  localparam logic [23:0] TIMEOUT_RESET = 24'd65535;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] target_address;
    logic       is_read;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic [3:0] bus_event;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [2:0] error_code;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic    produce;
    result_t res;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/i2cmts_item_if.sv @@
`default_nettype none

interface i2cmts_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] target_address;
  logic       is_read;
  logic [7:0] byte_count;
  logic [7:0] write_byte;
  logic [3:0] bus_event;
  logic [7:0] received_byte;

  modport source (
    output valid, kind, target_address, is_read, byte_count, write_byte, bus_event,
           received_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, target_address, is_read, byte_count, write_byte, bus_event,
           received_byte,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/i2cmts_result_if.sv @@
`default_nettype none

interface i2cmts_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;
  logic [2:0] error_code;
  logic       busy_res;

  modport source (
    output valid, bus_action, tx_byte, rx_valid, rx_byte, done_res, error_code, busy_res,
    input  ready
  );

  modport sink (
    input  valid, bus_action, tx_byte, rx_valid, rx_byte, done_res, error_code, busy_res,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/i2cmts_core.sv @@
`default_nettype none
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cmts_core
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire item_t       item,
  input  wire logic [23:0] timeout_ticks,
  output step_t            step
);

  localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [7:0]        DEPTH_B = 8'(BUFFER_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUFFER_DEPTH);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;

  logic [1:0]        phase, phase_next;
  logic [7:0]        address_byte, address_byte_next;
  logic [7:0]        byte_position, byte_position_next;
  logic [7:0]        transfer_length, transfer_length_next;
  logic [23:0]       idle_tick_count, idle_tick_count_next;
  logic [FILL_W-1:0] write_fill, write_fill_next;

  logic [7:0] write_store [BUFFER_DEPTH];
  logic [7:0] store_rd_data;
  logic       store_we;
  logic [IDX_W-1:0] store_waddr, store_raddr;

  logic [7:0]  pos_inc, pos_after;
  logic [23:0] tick_inc;
  logic        more, bad_param, wr_ev, rd_ev;

  assign pos_inc   = byte_position + 8'd1;
  assign more      = byte_position < transfer_length;
  assign pos_after = more ? pos_inc : byte_position;
  assign tick_inc  = (idle_tick_count == '1) ? idle_tick_count : idle_tick_count + 24'd1;
  assign bad_param = (item.target_address > ADDR_LIMIT) || (item.byte_count == 8'd0) ||
                     (item.byte_count > DEPTH_B);
  assign wr_ev = item.bus_event inside {[EV_WR_ADDR_ACK:EV_WR_DATA_NACK]};
  assign rd_ev = item.bus_event inside {[EV_RD_ADDR_ACK:EV_RD_DATA_NACK]};
  assign store_waddr = write_fill[IDX_W-1:0];
  assign store_raddr = byte_position_next[IDX_W-1:0];

  always_comb begin
    phase_next           = phase;
    address_byte_next    = address_byte;
    byte_position_next   = byte_position;
    transfer_length_next = transfer_length;
    idle_tick_count_next = idle_tick_count;
    write_fill_next      = write_fill;
    store_we             = 1'b0;
    step                 = '0;
    if (fire) begin
      case (item.kind)
        KIND_PUSH: begin
          if (phase == PH_IDLE && write_fill < DEPTH_F) begin
            store_we        = 1'b1;
            write_fill_next = write_fill + FILL_W'(1);
          end
        end
        KIND_START: begin
          step.produce = 1'b1;
          if (phase != PH_IDLE) begin
            step.res.done_res   = 1'b1;
            step.res.error_code = ERR_BUSY;
          end else if (bad_param) begin
            step.res.done_res   = 1'b1;
            step.res.error_code = ERR_PARAM;
          end else begin
            phase_next           = item.is_read ? PH_READ : PH_WRITE;
            address_byte_next    = {item.target_address[6:0], item.is_read};
            byte_position_next   = 8'd0;
            transfer_length_next = item.byte_count;
            idle_tick_count_next = 24'd0;
            if (!item.is_read) begin
              write_fill_next = '0;
            end
          end
        end
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            step.produce         = 1'b1;
            idle_tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              phase_next          = PH_IDLE;
              step.res.bus_action = ACT_RELEASE;
              step.res.done_res   = 1'b1;
              step.res.error_code = ERR_TIMEOUT;
            end
          end
        end
        default: begin
          if (phase != PH_IDLE) begin
            step.produce         = 1'b1;
            idle_tick_count_next = 24'd0;
            if ((wr_ev && phase != PH_WRITE) || (rd_ev && phase != PH_READ)) begin
              phase_next          = PH_IDLE;
              step.res.bus_action = ACT_RELEASE;
              step.res.done_res   = 1'b1;
              step.res.error_code = ERR_UNEXPECTED;
            end else begin
              case (item.bus_event)
                EV_START_SENT: begin
                  step.res.bus_action = ACT_SEND;
                  step.res.tx_byte    = address_byte;
                end
                EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
                  if (more && byte_position < DEPTH_B) begin
                    step.res.bus_action = ACT_SEND;
                    step.res.tx_byte    = store_rd_data;
                    byte_position_next  = pos_inc;
                  end else begin
                    phase_next          = PH_IDLE;
                    step.res.bus_action = ACT_STOP;
                    step.res.done_res   = 1'b1;
                    step.res.error_code = ERR_OK;
                  end
                end
                EV_WR_ADDR_NACK, EV_WR_DATA_NACK: begin
                  phase_next          = PH_IDLE;
                  step.res.bus_action = ACT_STOP;
                  step.res.done_res   = 1'b1;
                  step.res.error_code = ERR_WRITE_NACK;
                end
                EV_RD_ADDR_ACK: begin
                  step.res.bus_action = ACT_ACK;
                end
                EV_RD_ADDR_NACK: begin
                  phase_next          = PH_IDLE;
                  step.res.bus_action = ACT_STOP;
                  step.res.done_res   = 1'b1;
                  step.res.error_code = ERR_READ;
                end
                EV_RD_DATA_ACK: begin
                  byte_position_next  = pos_after;
                  step.res.bus_action = (pos_after < transfer_length) ? ACT_ACK : ACT_NACK;
                  step.res.rx_valid   = more;
                  step.res.rx_byte    = more ? item.received_byte : 8'd0;
                end
                EV_RD_DATA_NACK: begin
                  byte_position_next  = pos_after;
                  phase_next          = PH_IDLE;
                  step.res.bus_action = ACT_STOP;
                  step.res.rx_valid   = more;
                  step.res.rx_byte    = more ? item.received_byte : 8'd0;
                  step.res.done_res   = 1'b1;
                  step.res.error_code = (pos_after < transfer_length) ? ERR_READ : ERR_OK;
                end
                default: begin
                  phase_next          = PH_IDLE;
                  step.res.bus_action = ACT_RELEASE;
                  step.res.done_res   = 1'b1;
                  step.res.error_code = ERR_UNEXPECTED;
                end
              endcase
            end
          end
        end
      endcase
    end
    step.res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      address_byte    <= 8'd0;
      byte_position   <= 8'd0;
      transfer_length <= 8'd0;
      idle_tick_count <= 24'd0;
      write_fill      <= '0;
    end else begin
      phase           <= phase_next;
      address_byte    <= address_byte_next;
      byte_position   <= byte_position_next;
      transfer_length <= transfer_length_next;
      idle_tick_count <= idle_tick_count_next;
      write_fill      <= write_fill_next;
    end
  end

  // store read is prefetched at the next byte position
  always_ff @(posedge clk) begin
    if (store_we) begin
      write_store[store_waddr] <= item.write_byte;
    end
    if (store_we && store_waddr == store_raddr) begin
      store_rd_data <= item.write_byte;
    end else begin
      store_rd_data <= write_store[store_raddr];
    end
  end

  `I2CMTS_ASSERT_NEXT(a_end_goes_idle, clk, rst,
    fire && step.res.done_res && step.res.error_code != ERR_BUSY, phase == PH_IDLE,
    "transaction end did not return to idle")
  `I2CMTS_ASSERT_IMPL(a_rx_only_in_read, clk, rst, fire && step.res.rx_valid,
    phase == PH_READ, "received byte outside a read")
  `I2CMTS_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, write_fill <= DEPTH_F,
    "write fill beyond buffer depth")
  `I2CMTS_ASSERT_NEXT(a_start_opens, clk, rst,
    fire && item.kind == KIND_START && step.produce && !step.res.done_res,
    phase != PH_IDLE && byte_position == 8'd0, "accepted start did not open a transaction")

endmodule

`default_nettype wire

@@ rtl/i2c_master_transaction_sequencer.sv @@
`default_nettype none

// byte-level i2c master sequencer. items on the item channel push write bytes,
// open a transaction (7-bit address, direction, length up to BUFFER_DEPTH),
// report classified bus events or count timer ticks; each start, event or tick
// during a transaction yields one result carrying the bus action to take, any
// received byte and, at the end, the error code. pushes, and events or ticks
// with no transaction open, yield no result. one item is taken every cycle
// while the result side keeps up; each result is registered: the decision step
// runs from the input register into the result register, with the write buffer
// read prefetched at the current byte position. a waiting result holds off at
// most one more item in the input register. timeout_ticks is written through
// cfg_we/cfg_data, by the user only while idle; the block does not enforce it.
module i2c_master_transaction_sequencer
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  i2cmts_item_if.sink      item,
  i2cmts_result_if.source  result,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_data
);

  logic        in_valid;
  item_t       in_item;
  logic        in_go;
  logic        out_valid;
  result_t     out_res;
  logic [23:0] timeout_ticks;
  step_t       step;

  assign in_go      = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_item.kind           <= item.kind;
      in_item.target_address <= item.target_address;
      in_item.is_read        <= item.is_read;
      in_item.byte_count     <= item.byte_count;
      in_item.write_byte     <= item.write_byte;
      in_item.bus_event      <= item.bus_event;
      in_item.received_byte  <= item.received_byte;
    end
  end

  i2cmts_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (in_go),
    .item         (in_item),
    .timeout_ticks(timeout_ticks),
    .step         (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_go && step.produce) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && step.produce) begin
      out_res <= step.res;
    end
  end

  assign result.valid      = out_valid;
  assign result.bus_action = out_res.bus_action;
  assign result.tx_byte    = out_res.tx_byte;
  assign result.rx_valid   = out_res.rx_valid;
  assign result.rx_byte    = out_res.rx_byte;
  assign result.done_res   = out_res.done_res;
  assign result.error_code = out_res.error_code;
  assign result.busy_res   = out_res.busy_res;

endmodule

`default_nettype wire
